### design/rcp_pkg.sv
package rcp_pkg;

   // Field widths
   localparam int PAGE_W  = 16;
   localparam int ZOOM_W  = 16;
   localparam int BYTES_W = 32;
   localparam int ACT_W   = 2;
   localparam int SLOT_W  = 4;
   localparam int EVCNT_W = 5;
   localparam int MAXE_W  = 5;
   localparam int THR_W   = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Default sizing
   localparam int DEF_ENTRIES        = 16;
   localparam int DEF_ZOOM_FRAC_BITS = 8;

   // Percent times two: the refresh test compares against a half-sum of zooms
   localparam int SCALE_W = 8;
   localparam logic [SCALE_W-1:0] REFRESH_SCALE = 8'd200;
   localparam int DIFF_PROD_W = ZOOM_W + SCALE_W;
   localparam int SUM_PROD_W  = 32;

   // Response actions
   localparam logic [ACT_W-1:0] ACT_HIT             = 2'd0;
   localparam logic [ACT_W-1:0] ACT_RENDER_CACHE    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RENDER_UNCACHED = 2'd2;
   localparam logic [ACT_W-1:0] ACT_PAGE_MISSING    = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ENTRIES       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_BYTES         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REFRESH_THRESHOLD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RENDER_ZOOM   = 2'd3;

   // Register reset values
   localparam logic [MAXE_W-1:0]  RST_MAX_ENTRIES       = 5'd16;
   localparam logic [BYTES_W-1:0] RST_MAX_BYTES         = 32'hFFFF_FFFF;
   localparam logic [THR_W-1:0]   RST_REFRESH_THRESHOLD = 15'd0;
   localparam logic [ZOOM_W-1:0]  RST_MIN_RENDER_ZOOM   = 16'd256;

   typedef struct packed {
      logic [PAGE_W-1:0]  page_id;
      logic [ZOOM_W-1:0]  zoom;
      logic [BYTES_W-1:0] render_bytes;
      logic               page_exists;
   } req_type;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [SLOT_W-1:0]  slot;
      logic [ZOOM_W-1:0]  render_zoom;
      logic [EVCNT_W-1:0] evicted_count;
      logic [BYTES_W-1:0] bytes_in_use;
   } rsp_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [ZOOM_W-1:0]  zoom;
      logic [BYTES_W-1:0] size;
   } entry_type;

endpackage

### design/rcp_zoom_cmp.sv
module rcp_zoom_cmp #(
   parameter int ZOOM_FRAC_BITS = rcp_pkg::DEF_ZOOM_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rcp_pkg::ZOOM_W-1:0]  want_zoom,
   input  logic [rcp_pkg::ZOOM_W-1:0]  old_zoom,
   input  logic [rcp_pkg::THR_W-1:0]   threshold,
   output logic                        done,
   output logic                        refresh
);

   localparam int LHS_W = rcp_pkg::DIFF_PROD_W + ZOOM_FRAC_BITS;
   localparam int CMP_W = (LHS_W > rcp_pkg::SUM_PROD_W) ? LHS_W : rcp_pkg::SUM_PROD_W;

   logic                              vld1_ff, vld1_in;
   logic                              gt_ff, gt_in;
   logic [rcp_pkg::DIFF_PROD_W-1:0]   lhs_ff, lhs_in;
   logic [rcp_pkg::SUM_PROD_W-1:0]    rhs_ff, rhs_in;
   logic                              done_ff, done_in;
   logic                              refresh_ff, refresh_in;
   logic [rcp_pkg::ZOOM_W-1:0]        diff;
   logic [rcp_pkg::ZOOM_W:0]          zsum;
   logic [LHS_W-1:0]                  lhs_scaled;

   // Stage one: zoom rise times scale, threshold times zoom sum
   always_comb begin
      diff    = want_zoom - old_zoom;
      zsum    = {1'b0, want_zoom} + {1'b0, old_zoom};
      vld1_in = start;
      gt_in   = want_zoom > old_zoom;
      lhs_in  = rcp_pkg::DIFF_PROD_W'(diff) * rcp_pkg::DIFF_PROD_W'(rcp_pkg::REFRESH_SCALE);
      rhs_in  = rcp_pkg::SUM_PROD_W'(threshold) * rcp_pkg::SUM_PROD_W'(zsum);
   end

   // Stage two: apply fraction scale and compare
   always_comb begin
      lhs_scaled = {lhs_ff, {ZOOM_FRAC_BITS{1'b0}}};
      done_in    = vld1_ff;
      refresh_in = gt_ff && (CMP_W'(lhs_scaled) > CMP_W'(rhs_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         vld1_ff <= vld1_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      gt_ff      <= gt_in;
      lhs_ff     <= lhs_in;
      rhs_ff     <= rhs_in;
      refresh_ff <= refresh_in;
   end

   assign done    = done_ff;
   assign refresh = refresh_ff;

endmodule

### design/render_cache_policy_core.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  rcp_pkg::req_type (page, zoom, bytes, exists)
// rsp_      out        rsp_valid / rsp_ready  rcp_pkg::rsp_type (action, slot, zoom, ...)
// csr_      in         csr_we                 csr_index, csr_wdata
//
// One request at a time. Every request sweeps the entry memory through its single
// read port, then a hit goes through the zoom compare before it is answered.
// A render that is cached runs one eviction after another, then shifts the age list;
// on a refresh it first walks the age list to locate the old copy.
// Reset is synchronous; the valid bits clear at once, so no clearing pass is run.
// A finished response waits in the output register; the next request is taken meanwhile.
module render_cache_policy_core #(
   parameter int ENTRIES        = rcp_pkg::DEF_ENTRIES,
   parameter int ZOOM_FRAC_BITS = rcp_pkg::DEF_ZOOM_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  rcp_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output rcp_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [rcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rcp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > rcp_pkg::MAXE_W) ? CNT_W : rcp_pkg::MAXE_W;

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b0000_0000_0001,
      ST_LOOKUP   = 12'b0000_0000_0010,
      ST_DECIDE   = 12'b0000_0000_0100,
      ST_REFRESH  = 12'b0000_0000_1000,
      ST_FIND     = 12'b0000_0001_0000,
      ST_DROP     = 12'b0000_0010_0000,
      ST_EV_CHECK = 12'b0000_0100_0000,
      ST_EV_SLOT  = 12'b0000_1000_0000,
      ST_EV_SIZE  = 12'b0001_0000_0000,
      ST_SHIFT    = 12'b0010_0000_0000,
      ST_INSERT   = 12'b0100_0000_0000,
      ST_RESULT   = 12'b1000_0000_0000
   } state_type;

   // Control and working registers
   state_type                      state_ff, state_in;
   rcp_pkg::req_type               req_ff, req_in;
   logic [rcp_pkg::ZOOM_W-1:0]     want_ff, want_in;
   logic [CNT_W-1:0]               sweep_ff, sweep_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]               rd_idx_ff, rd_idx_in;
   logic                           hit_ff, hit_in;
   logic [IDX_W-1:0]               hit_slot_ff, hit_slot_in;
   logic [rcp_pkg::ZOOM_W-1:0]     hit_zoom_ff, hit_zoom_in;
   logic [rcp_pkg::BYTES_W-1:0]    hit_size_ff, hit_size_in;
   logic [IDX_W-1:0]               hit_pos_ff, hit_pos_in;
   logic                           free_ok_ff, free_ok_in;
   logic [IDX_W-1:0]               free_slot_ff, free_slot_in;
   logic [CNT_W-1:0]               n_ff, n_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [rcp_pkg::BYTES_W-1:0]    total_ff, total_in;
   logic [CNT_W-1:0]               evict_ff, evict_in;
   logic [IDX_W-1:0]               ev_slot_ff, ev_slot_in;
   logic [rcp_pkg::ACT_W-1:0]      action_ff, action_in;
   logic [IDX_W-1:0]               res_slot_ff, res_slot_in;
   logic [ENTRIES-1:0]             valid_ff, valid_in;
   rcp_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Configuration registers
   logic [rcp_pkg::MAXE_W-1:0]     max_entries_ff;
   logic [rcp_pkg::BYTES_W-1:0]    max_bytes_ff;
   logic [rcp_pkg::THR_W-1:0]      threshold_ff;
   logic [rcp_pkg::ZOOM_W-1:0]     min_zoom_ff;

   // Memories: entry data by slot, slot list by age (newest first)
   rcp_pkg::entry_type             entry_mem [ENTRIES];
   logic [IDX_W-1:0]               order_mem [ENTRIES];
   rcp_pkg::entry_type             entry_rd_ff;
   logic [IDX_W-1:0]               order_rd_ff;
   logic [IDX_W-1:0]               entry_raddr, entry_waddr;
   logic                           entry_we;
   rcp_pkg::entry_type             entry_wdata;
   logic [IDX_W-1:0]               order_raddr, order_waddr, order_wdata;
   logic                           order_we;

   // Helpers
   logic                           zcmp_start, zcmp_done, zcmp_refresh;
   logic                           req_fire;
   logic                           page_match;
   logic                           over_budget, at_limit, hit_before;
   logic [CNT_W-1:0]               ev_pos, shift_top, sweep_dec;
   logic [rcp_pkg::BYTES_W:0]      budget_sum;

   rcp_zoom_cmp #(
      .ZOOM_FRAC_BITS(ZOOM_FRAC_BITS)
   ) u_zoom_cmp (
      .clock     (clock),
      .reset     (reset),
      .start     (zcmp_start),
      .want_zoom (want_ff),
      .old_zoom  (hit_zoom_ff),
      .threshold (threshold_ff),
      .done      (zcmp_done),
      .refresh   (zcmp_refresh)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Budget and position terms
   always_comb begin
      page_match  = rd_vld_ff && valid_ff[rd_idx_ff] && (entry_rd_ff.page == req_ff.page_id);
      budget_sum  = {1'b0, total_ff} + {1'b0, req_ff.render_bytes};
      over_budget = budget_sum > {1'b0, max_bytes_ff};
      at_limit    = (CMP_W'(n_ff) >= CMP_W'(max_entries_ff)) || (n_ff == CNT_W'(ENTRIES));
      hit_before  = hit_ff && (CNT_W'(hit_pos_ff) < n_ff);
      ev_pos      = hit_before ? n_ff : n_ff - CNT_W'(1);
      shift_top   = hit_before ? CNT_W'(hit_pos_ff) : n_ff;
      sweep_dec   = sweep_ff - CNT_W'(1);
   end

   // Request sequencer
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      want_in      = want_ff;
      sweep_in     = sweep_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_zoom_in  = hit_zoom_ff;
      hit_size_in  = hit_size_ff;
      hit_pos_in   = hit_pos_ff;
      free_ok_in   = free_ok_ff;
      free_slot_in = free_slot_ff;
      n_in         = n_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      evict_in     = evict_ff;
      ev_slot_in   = ev_slot_ff;
      action_in    = action_ff;
      res_slot_in  = res_slot_ff;
      valid_in     = valid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      entry_raddr  = '0;
      entry_we     = 1'b0;
      entry_waddr  = free_slot_ff;
      entry_wdata  = '{page: req_ff.page_id, zoom: want_ff, size: req_ff.render_bytes};
      order_raddr  = '0;
      order_we     = 1'b0;
      order_waddr  = rd_idx_ff;
      order_wdata  = order_rd_ff;
      zcmp_start   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // Latch the request and start the table sweep
            if (req_fire) begin
               req_in     = req_data;
               want_in    = (req_data.zoom > min_zoom_ff) ? req_data.zoom : min_zoom_ff;
               sweep_in   = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               evict_in   = '0;
               state_in   = ST_LOOKUP;
            end
         end

         ST_LOOKUP: begin
            // Issue one slot read a cycle, check the returning entry
            if (sweep_ff != CNT_W'(ENTRIES)) begin
               entry_raddr = sweep_ff[IDX_W-1:0];
               rd_vld_in   = 1'b1;
               rd_idx_in   = sweep_ff[IDX_W-1:0];
               sweep_in    = sweep_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_DECIDE;
            end
            if (page_match && !hit_ff) begin
               hit_in      = 1'b1;
               hit_slot_in = rd_idx_ff;
               hit_zoom_in = entry_rd_ff.zoom;
               hit_size_in = entry_rd_ff.size;
            end
            if (rd_vld_ff && !valid_ff[rd_idx_ff] && !free_ok_ff) begin
               free_ok_in   = 1'b1;
               free_slot_in = rd_idx_ff;
            end
         end

         ST_DECIDE: begin
            if (hit_ff) begin
               zcmp_start = 1'b1;
               state_in   = ST_REFRESH;
            end else if (!req_ff.page_exists) begin
               action_in   = rcp_pkg::ACT_PAGE_MISSING;
               res_slot_in = '0;
               state_in    = ST_RESULT;
            end else if (max_entries_ff == '0) begin
               action_in   = rcp_pkg::ACT_RENDER_UNCACHED;
               res_slot_in = '0;
               state_in    = ST_RESULT;
            end else begin
               n_in     = count_ff;
               state_in = ST_EV_CHECK;
            end
         end

         ST_REFRESH: begin
            // Wait for the zoom compare
            if (zcmp_done) begin
               if (!zcmp_refresh) begin
                  action_in   = rcp_pkg::ACT_HIT;
                  res_slot_in = hit_slot_ff;
                  state_in    = ST_RESULT;
               end else if (max_entries_ff == '0) begin
                  action_in   = rcp_pkg::ACT_RENDER_UNCACHED;
                  res_slot_in = '0;
                  state_in    = ST_RESULT;
               end else begin
                  sweep_in = '0;
                  state_in = ST_FIND;
               end
            end
         end

         ST_FIND: begin
            // Walk the age list for the old copy's position
            if (sweep_ff != count_ff) begin
               order_raddr = sweep_ff[IDX_W-1:0];
               rd_vld_in   = 1'b1;
               rd_idx_in   = sweep_ff[IDX_W-1:0];
               sweep_in    = sweep_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_DROP;
            end
            if (rd_vld_ff && (order_rd_ff == hit_slot_ff)) begin
               hit_pos_in = rd_idx_ff;
            end
         end

         ST_DROP: begin
            // Remove the old copy; it does not count as an eviction
            valid_in[hit_slot_ff] = 1'b0;
            total_in = total_ff - hit_size_ff;
            n_in     = count_ff - CNT_W'(1);
            if (!free_ok_ff || (hit_slot_ff < free_slot_ff)) begin
               free_ok_in   = 1'b1;
               free_slot_in = hit_slot_ff;
            end
            state_in = ST_EV_CHECK;
         end

         ST_EV_CHECK: begin
            // Evict the oldest while at the count limit or over the byte budget
            if ((n_ff != '0) && (at_limit || over_budget)) begin
               order_raddr = ev_pos[IDX_W-1:0];
               state_in    = ST_EV_SLOT;
            end else begin
               sweep_in = shift_top;
               state_in = ST_SHIFT;
            end
         end

         ST_EV_SLOT: begin
            entry_raddr = order_rd_ff;
            ev_slot_in  = order_rd_ff;
            state_in    = ST_EV_SIZE;
         end

         ST_EV_SIZE: begin
            valid_in[ev_slot_ff] = 1'b0;
            total_in = total_ff - entry_rd_ff.size;
            n_in     = n_ff - CNT_W'(1);
            evict_in = evict_ff + CNT_W'(1);
            if (!free_ok_ff || (ev_slot_ff < free_slot_ff)) begin
               free_ok_in   = 1'b1;
               free_slot_in = ev_slot_ff;
            end
            state_in = ST_EV_CHECK;
         end

         ST_SHIFT: begin
            // Move list positions down by one, from the top toward the front
            if (sweep_ff != '0) begin
               order_raddr = sweep_dec[IDX_W-1:0];
               rd_vld_in   = 1'b1;
               rd_idx_in   = sweep_ff[IDX_W-1:0];
               sweep_in    = sweep_dec;
            end else if (!rd_vld_ff) begin
               state_in = ST_INSERT;
            end
            if (rd_vld_ff) begin
               order_we = 1'b1;
            end
         end

         ST_INSERT: begin
            // Store the new render at the lowest free slot, front of the list
            entry_we    = 1'b1;
            order_we    = 1'b1;
            order_waddr = '0;
            order_wdata = free_slot_ff;
            valid_in[free_slot_ff] = 1'b1;
            count_in    = n_ff + CNT_W'(1);
            total_in    = total_ff + req_ff.render_bytes;
            action_in   = rcp_pkg::ACT_RENDER_CACHE;
            res_slot_in = free_slot_ff;
            state_in    = ST_RESULT;
         end

         ST_RESULT: begin
            // Load the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.action        = action_ff;
               rsp_in.slot          = rcp_pkg::SLOT_W'(res_slot_ff);
               rsp_in.render_zoom   = ((action_ff == rcp_pkg::ACT_RENDER_CACHE) ||
                                       (action_ff == rcp_pkg::ACT_RENDER_UNCACHED)) ?
                                      want_ff : '0;
               rsp_in.evicted_count = rcp_pkg::EVCNT_W'(evict_ff);
               rsp_in.bytes_in_use  = total_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working payload
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      want_ff      <= want_in;
      sweep_ff     <= sweep_in;
      rd_idx_ff    <= rd_idx_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      hit_zoom_ff  <= hit_zoom_in;
      hit_size_ff  <= hit_size_in;
      hit_pos_ff   <= hit_pos_in;
      free_ok_ff   <= free_ok_in;
      free_slot_ff <= free_slot_in;
      n_ff         <= n_in;
      evict_ff     <= evict_in;
      ev_slot_ff   <= ev_slot_in;
      action_ff    <= action_in;
      res_slot_ff  <= res_slot_in;
      rsp_ff       <= rsp_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= rcp_pkg::RST_MAX_ENTRIES;
         max_bytes_ff   <= rcp_pkg::RST_MAX_BYTES;
         threshold_ff   <= rcp_pkg::RST_REFRESH_THRESHOLD;
         min_zoom_ff    <= rcp_pkg::RST_MIN_RENDER_ZOOM;
      end else if (csr_we) begin
         unique case (csr_index)
            rcp_pkg::REG_MAX_ENTRIES:
               max_entries_ff <= csr_wdata[rcp_pkg::MAXE_W-1:0];
            rcp_pkg::REG_MAX_BYTES:
               max_bytes_ff <= csr_wdata[rcp_pkg::BYTES_W-1:0];
            rcp_pkg::REG_REFRESH_THRESHOLD:
               threshold_ff <= csr_wdata[rcp_pkg::THR_W-1:0];
            rcp_pkg::REG_MIN_RENDER_ZOOM:
               min_zoom_ff <= csr_wdata[rcp_pkg::ZOOM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Entry memory
   always_ff @(posedge clock) begin
      if (entry_we) begin
         entry_mem[entry_waddr] <= entry_wdata;
      end
      entry_rd_ff <= entry_mem[entry_raddr];
   end

   // Age list memory
   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
      order_rd_ff <= order_mem[order_raddr];
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count exceeds table depth");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_ff) == int'(count_ff)))
      else $error("entry count disagrees with valid bits");

   a_insert_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |-> (free_ok_ff && !valid_ff[free_slot_ff]))
      else $error("insert without a free slot");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside result state");
`endif

endmodule

### verif/render_cache_checker.sv
`timescale 1ns / 100ps

module render_cache_checker
   import rcp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    errors,
   output int                    pending,
   output int                    checked
);

   localparam int SLOTS     = DEF_ENTRIES;
   localparam int FRAC_BITS = DEF_ZOOM_FRAC_BITS;
   localparam int MAX_SHOWN = 60;

   // Shadow copy of the registers
   logic [MAXE_W-1:0]  cfg_max_entries;
   logic [BYTES_W-1:0] cfg_max_bytes;
   logic [THR_W-1:0]   cfg_threshold;
   logic [ZOOM_W-1:0]  cfg_min_zoom;

   // Shadow copy of the cache table; age 0 is the newest entry
   logic               cached    [SLOTS];
   entry_type          entry_tab [SLOTS];
   int                 age_tab   [SLOTS];
   logic [BYTES_W-1:0] bytes_total;

   // Responses owed, oldest first
   rsp_type            answer_q [$];

   initial begin
      errors  = 0;
      pending = 0;
      checked = 0;
   end

   task automatic report_mismatch(input string msg);
      if (errors < MAX_SHOWN)
         $display("%0t: %s", $realtime, msg);
      errors++;
   endtask

   // Remove one entry and close the gap it leaves in the age order
   function automatic void drop_entry(input int s);
      int i;
      cached[s]   = 1'b0;
      bytes_total = bytes_total - entry_tab[s].size;
      for (i = 0; i < SLOTS; i++)
         if (cached[i] && age_tab[i] > age_tab[s])
            age_tab[i]--;
   endfunction

   // Work out the response to one request and update the shadow table
   function automatic rsp_type predict_placement(input req_type r);
      rsp_type            e;
      logic [ZOOM_W-1:0]  want;
      logic [ZOOM_W-1:0]  old_zoom;
      logic [63:0]        grow;
      logic [63:0]        span;
      logic               refresh;
      int                 hit, i, n, lim, slot, evicted, victim;

      e        = '0;
      want     = (r.zoom > cfg_min_zoom) ? r.zoom : cfg_min_zoom;
      hit      = -1;
      refresh  = 1'b0;
      slot     = 0;
      evicted  = 0;
      for (i = SLOTS - 1; i >= 0; i--)
         if (cached[i] && entry_tab[i].page == r.page_id)
            hit = i;

      // Refresh when the zoom grows by more than the threshold percent
      if (hit >= 0) begin
         old_zoom = entry_tab[hit].zoom;
         if (want > old_zoom) begin
            grow    = (64'(want) - 64'(old_zoom)) * 64'd200 * (64'd1 << FRAC_BITS);
            span    = 64'(cfg_threshold) * (64'(old_zoom) + 64'(want));
            refresh = grow > span;
         end
      end

      if (hit >= 0 && !refresh) begin
         e.action = ACT_HIT;
         e.slot   = SLOT_W'(hit);
      end else if (hit < 0 && !r.page_exists) begin
         e.action = ACT_PAGE_MISSING;
      end else if (cfg_max_entries == '0) begin
         e.action      = ACT_RENDER_UNCACHED;
         e.render_zoom = want;
      end else begin
         // Drop the stale copy, then evict oldest while over either budget
         if (hit >= 0)
            drop_entry(hit);
         lim = (int'(cfg_max_entries) > SLOTS) ? SLOTS : int'(cfg_max_entries);
         n = 0;
         for (i = 0; i < SLOTS; i++)
            if (cached[i])
               n++;
         while (n > 0 && (n >= lim ||
                64'(bytes_total) + 64'(r.render_bytes) > 64'(cfg_max_bytes))) begin
            victim = -1;
            for (i = SLOTS - 1; i >= 0; i--)
               if (cached[i] && age_tab[i] == n - 1)
                  victim = i;
            if (victim < 0)
               break;
            drop_entry(victim);
            n--;
            evicted++;
         end

         // Age the survivors and place the new render in the lowest free slot
         for (i = 0; i < SLOTS; i++)
            if (cached[i])
               age_tab[i]++;
         for (i = SLOTS - 1; i >= 0; i--)
            if (!cached[i])
               slot = i;
         cached[slot]         = 1'b1;
         entry_tab[slot].page = r.page_id;
         entry_tab[slot].zoom = want;
         entry_tab[slot].size = r.render_bytes;
         age_tab[slot]        = 0;
         bytes_total          = bytes_total + r.render_bytes;

         e.action        = ACT_RENDER_CACHE;
         e.slot          = SLOT_W'(slot);
         e.render_zoom   = want;
         e.evicted_count = EVCNT_W'(evicted);
      end
      e.bytes_in_use = bytes_total;
      return e;
   endfunction

   // Follow register writes, check each response, predict each request
   always @(posedge clock) begin : watch_channels
      rsp_type want_rsp;
      int      i;
      if (reset) begin
         cfg_max_entries = RST_MAX_ENTRIES;
         cfg_max_bytes   = RST_MAX_BYTES;
         cfg_threshold   = RST_REFRESH_THRESHOLD;
         cfg_min_zoom    = RST_MIN_RENDER_ZOOM;
         for (i = 0; i < SLOTS; i++)
            cached[i] = 1'b0;
         bytes_total = '0;
         answer_q.delete();
         pending = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_MAX_ENTRIES:       cfg_max_entries = csr_wdata[MAXE_W-1:0];
               REG_MAX_BYTES:         cfg_max_bytes   = csr_wdata[BYTES_W-1:0];
               REG_REFRESH_THRESHOLD: cfg_threshold   = csr_wdata[THR_W-1:0];
               REG_MIN_RENDER_ZOOM:   cfg_min_zoom    = csr_wdata[ZOOM_W-1:0];
            endcase
         end

         if (rsp_valid && rsp_ready) begin
            checked++;
            if (answer_q.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with no request outstanding",
                                         checked));
            end else begin
               want_rsp = answer_q.pop_front();
               if (rsp_data.action !== want_rsp.action)
                  report_mismatch($sformatf("response %0d: action %0h, expected %0h",
                                            checked, rsp_data.action, want_rsp.action));
               if (rsp_data.slot !== want_rsp.slot)
                  report_mismatch($sformatf("response %0d: slot %0h, expected %0h",
                                            checked, rsp_data.slot, want_rsp.slot));
               if (rsp_data.render_zoom !== want_rsp.render_zoom)
                  report_mismatch($sformatf("response %0d: render_zoom %0h, expected %0h",
                                            checked, rsp_data.render_zoom,
                                            want_rsp.render_zoom));
               if (rsp_data.evicted_count !== want_rsp.evicted_count)
                  report_mismatch($sformatf("response %0d: evicted_count %0h, expected %0h",
                                            checked, rsp_data.evicted_count,
                                            want_rsp.evicted_count));
               if (rsp_data.bytes_in_use !== want_rsp.bytes_in_use)
                  report_mismatch($sformatf("response %0d: bytes_in_use %0h, expected %0h",
                                            checked, rsp_data.bytes_in_use,
                                            want_rsp.bytes_in_use));
            end
         end

         if (req_valid && req_ready)
            answer_q.push_back(predict_placement(req_data));
         pending = answer_q.size();
      end
   end

endmodule

### verif/tb_render_cache_policy_core.sv
`timescale 1ns / 100ps

module tb_render_cache_policy_core;
   import rcp_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 150;
   localparam int PHASE_ITEMS   = 215;
   localparam int POOL_SIZE     = 20;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_MAX_ENTRIES;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int errors;
   int pending;
   int checked;
   int cycles     = 0;
   int sent       = 0;
   int settings   = 1;
   int gap_pct    = 0;
   int stall_pct  = 0;
   int stall_left = 0;

   logic [PAGE_W-1:0]  page_pool [POOL_SIZE];
   logic [BYTES_W-1:0] byte_cap = '0;

   always #2 clock = ~clock;

   render_cache_policy_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   render_cache_checker watch (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .errors    (errors),
      .pending   (pending),
      .checked   (checked)
   );

   // Stall the response side in random bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!reset && $urandom_range(0, 99) < stall_pct) begin
         rsp_ready  <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses outstanding", cycles, pending);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic req_type make_request(input logic [PAGE_W-1:0] page,
                                            input logic [ZOOM_W-1:0] zoom,
                                            input logic [BYTES_W-1:0] bytes,
                                            input logic exists);
      req_type r;
      r.page_id      = page;
      r.zoom         = zoom;
      r.render_bytes = bytes;
      r.page_exists  = exists;
      return r;
   endfunction

   // Mostly pages from a small pool so hits and refreshes happen often
   function automatic req_type random_request();
      req_type r;
      r.page_id      = ($urandom_range(0, 99) < 85) ? page_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                    : PAGE_W'($urandom);
      r.zoom         = ($urandom_range(0, 3) == 0) ? ZOOM_W'($urandom)
                                                   : ZOOM_W'($urandom_range(32, 1200));
      r.render_bytes = ($urandom_range(0, 99) < 15) ? $urandom : $urandom_range(0, byte_cap);
      r.page_exists  = ($urandom_range(0, 99) < 80);
      return r;
   endfunction

   // Present one request, with an optional idle gap first; hold until accepted
   task automatic send_request(input req_type r);
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sent++;
   endtask

   // Drop valid and wait until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending != 0)
         @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // One block of random requests under a fresh register setting
   task automatic run_phase(input logic [31:0] max_entries, input logic [31:0] max_bytes,
                            input logic [31:0] threshold, input logic [31:0] min_zoom,
                            input bit calm);
      int k;
      @(posedge clock);
      write_reg(REG_MAX_ENTRIES, max_entries);
      write_reg(REG_MAX_BYTES, max_bytes);
      write_reg(REG_REFRESH_THRESHOLD, threshold);
      write_reg(REG_MIN_RENDER_ZOOM, min_zoom);
      csr_we <= 1'b0;
      for (k = 0; k < POOL_SIZE; k++)
         page_pool[k] = PAGE_W'($urandom);
      byte_cap  = max_bytes / 5;
      gap_pct   = calm ? 0 : 8 * $urandom_range(0, 3);
      stall_pct = calm ? 0 : 8 * $urandom_range(0, 3);
      for (k = 0; k < PHASE_ITEMS; k++)
         send_request(random_request());
      drain();
      settings++;
   endtask

   initial begin
      int i;
      gap_pct   = 15;
      stall_pct = 15;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings
      send_request(make_request('0, '0, '0, 1'b0));
      send_request(make_request('0, '0, 32'd100, 1'b1));
      send_request(make_request('0, 16'h0100, 32'd7, 1'b0));
      send_request(make_request('0, 16'h0101, 32'd200, 1'b0));
      send_request(make_request(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      send_request(make_request(16'hFFFF, '0, '0, 1'b0));
      send_request(make_request(16'd1, '0, '0, 1'b0));
      // Fill the table, then overflow the entry limit
      for (i = 1; i <= 16; i++)
         send_request(make_request(PAGE_W'(i), '0, '0, 1'b1));
      send_request(make_request(16'hAAAA, 16'h5555, 32'h5555_AAAA, 1'b1));
      drain();

      // Random part across several settings, extremes first
      run_phase(16, 32'hFFFF_FFFF, 0, 0, 1'b0);
      run_phase(4, 5000, 2560, 128, 1'b0);
      run_phase(0, 1000, 100, 256, 1'b0);
      run_phase(31, 0, 32767, 65535, 1'b0);
      run_phase(1, 40000, 512, 300, 1'b0);
      run_phase($urandom_range(1, 16), $urandom, $urandom_range(0, 32767),
                $urandom_range(0, 1024), 1'b0);
      run_phase($urandom_range(2, 16), $urandom_range(1000, 100000), $urandom_range(0, 6000),
                $urandom_range(0, 512), 1'b0);
      run_phase(16, 200000, 1280, 256, 1'b1);

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d requests under %0d register settings; %0d responses compared",
               sent, settings, checked);
      if (pending != 0)
         $display("%0d responses never arrived", pending);
      if (errors == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
